### hdl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ACSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ACSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ACSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACSS_ASSERT(lbl, prop, msg)
`define ACSS_ASSERT_IMPL(lbl, ante, cons, msg)
`define ACSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/acss_pkg.sv
// Types and constants of the converter channel sweep scheduler
`timescale 1ns / 1ps
package acss_pkg;
  localparam int unsigned CHANNELS   = 4;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned ADDR_W     = 3;

  localparam logic [CH_W-1:0]    LAST_CH      = CH_W'(CHANNELS - 1);
  localparam logic [CNT_W-1:0]   RETRY_RESET  = CNT_W'(10);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET  = '0;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_RESULT_SHIFT = 1'b0,
    REG_RETRY_RELOAD = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_SRD,
    ST_SOUT,
    ST_STAT
  } state_e;

  typedef struct packed {
    logic [1:0]       pad;
    logic             sweep_done;
    logic [CH_W-1:0]  start_channel;
    logic             start_conversion;
    logic [VAL_W-1:0] sample_value;
    logic [CH_W-1:0]  sample_channel;
  } out_data_t;
endpackage

### hdl/adc_channel_sweep_scheduler_top.sv
// Top level of the converter channel sweep scheduler
// A poll's status result is registered at the output after the update and status states.
// A new poll is taken only in the idle state. A poll that completes a sweep makes four sample
// reads, each through a read and an output state; the output states wait on master stalls.
// Reset: rst_ni clears the channel pointer, the retry valid bits, the output valid bit and
// the configuration registers (shift 0, reload 10); the memories are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module adc_channel_sweep_scheduler_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [acss_pkg::VAL_W-1:0]      s_axis_tdata,  // conv_value [15:0]
  input  logic                            s_axis_tuser,  // conv_ready [0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // sample_channel [1:0], sample_value [17:2], start_conversion [18],
  // start_channel [20:19], sweep_done [21], zero [23:22]
  output logic [acss_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,  // is_sample [0]
  output logic                            m_axis_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [acss_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import acss_pkg::*;

  logic [SHIFT_W-1:0] shift_q;
  logic [CNT_W-1:0]   reload_q;
  logic               cfg_we;

  state_e state_q, state_d;
  logic [CH_W-1:0]  cur_q, cur_d;
  logic [CH_W-1:0]  idx_q, idx_d;
  logic             ready_q, done_q, start_q, start_d;
  logic [CHANNELS-1:0] rvalid_q, rvalid_d;

  logic [CNT_W-1:0] retry_mem [CHANNELS];
  logic [VAL_W-1:0] sample_mem [CHANNELS];
  logic [CNT_W-1:0] r_rdata_q;
  logic [VAL_W-1:0] s_rdata_q;

  logic             acc, in_done;
  logic [CH_W-1:0]  nch;
  logic             r_we;
  logic [CNT_W-1:0] r_wdata, eff, dec;
  logic             out_free, out_load;
  out_data_t        out_d, out_q;
  logic             out_user_d, out_user_q, out_last_d, out_last_q, m_valid_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(paddr[2]))
      REG_RESULT_SHIFT: prdata[SHIFT_W-1:0] = shift_q;
      REG_RETRY_RELOAD: prdata[CNT_W-1:0]   = reload_q;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= SHIFT_RESET;
      reload_q <= RETRY_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_RESULT_SHIFT: shift_q  <= pwdata[SHIFT_W-1:0];
        REG_RETRY_RELOAD: reload_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // poll intake
  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign in_done = s_axis_tuser && (cur_q == LAST_CH);
  always_comb begin
    if (!s_axis_tuser)  nch = cur_q;
    else if (in_done)   nch = '0;
    else                nch = cur_q + CH_W'(1);
  end

  // memories: sample written on intake of a ready conversion, retry counter read on intake
  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tuser) sample_mem[cur_q] <= s_axis_tdata >> shift_q;
    s_rdata_q <= sample_mem[idx_q];
    if (acc) r_rdata_q <= retry_mem[nch];
    if (r_we) retry_mem[cur_q] <= r_wdata;
  end

  // counter update: an entry without its valid bit, or any entry after a completed sweep, reads as zero
  assign eff = (rvalid_q[cur_q] && !done_q) ? r_rdata_q : '0;
  assign dec = (!ready_q && eff != '0) ? eff - CNT_W'(1) : eff;

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    start_d    = start_q;
    rvalid_d   = rvalid_q;
    r_we       = 1'b0;
    r_wdata    = dec;
    out_load   = 1'b0;
    out_d      = '0;
    out_user_d = 1'b0;
    out_last_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          cur_d   = nch;
          state_d = ST_RMW;
        end
      end
      ST_RMW: begin
        if (done_q) rvalid_d = '0;
        if (dec == '0) begin
          r_we    = 1'b1;
          r_wdata = reload_q;
          start_d = 1'b1;
        end else begin
          r_we    = !ready_q;
          start_d = 1'b0;
        end
        if (r_we) rvalid_d[cur_q] = 1'b1;
        idx_d   = '0;
        state_d = done_q ? ST_SRD : ST_STAT;
      end
      ST_SRD: state_d = ST_SOUT;
      ST_SOUT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_user_d           = 1'b1;
          out_d.sample_channel = idx_q;
          out_d.sample_value   = s_rdata_q;
          out_d.sweep_done     = 1'b1;
          if (idx_q == LAST_CH) begin
            state_d = ST_STAT;
          end else begin
            idx_d   = idx_q + CH_W'(1);
            state_d = ST_SRD;
          end
        end
      end
      ST_STAT: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_last_d             = 1'b1;
          out_d.start_conversion = start_q;
          out_d.start_channel    = start_q ? cur_q : '0;
          out_d.sweep_done       = done_q;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cur_q    <= '0;
      idx_q    <= '0;
      start_q  <= 1'b0;
      rvalid_q <= '0;
      ready_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      idx_q    <= idx_d;
      start_q  <= start_d;
      rvalid_q <= rvalid_d;
      if (acc) begin
        ready_q <= s_axis_tuser;
        done_q  <= in_done;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q      <= out_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  `ACSS_ASSERT_NEXT(a_acc_to_rmw, acc, state_q == ST_RMW, "accepted poll did not enter update")
  `ACSS_ASSERT_IMPL(a_sweep_reload, state_q == ST_RMW && done_q, r_we && r_wdata == reload_q,
                    "completed sweep did not reload the counter")
  `ACSS_ASSERT_IMPL(a_sample_form, m_axis_tvalid && m_axis_tuser,
                    m_axis_tdata[21] && !m_axis_tlast, "malformed sample result")
  `ACSS_ASSERT_IMPL(a_status_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast,
                    "status result without last")
endmodule
